[rtl/dnle_pkg.sv]
package dnle_pkg;

  localparam logic [7:0] SEPARATOR     = 8'h2E;
  localparam logic [7:0] NAME_MAX_LEN  = 8'd253;
  localparam logic [7:0] LEN_SATURATE  = 8'd254;
  localparam logic [5:0] LABEL_MAX_LEN = 6'd63;

  // result queue geometry
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned MaxPush   = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_BAD_LABEL = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] out_offset;
    logic       store;
    logic       done_res;
    status_e    status;
  } res_t;

  // results of one character, in delivery order, ents[0] first
  typedef struct packed {
    logic [1:0]         n;
    res_t [MaxPush-1:0] ents;
  } push_t;

endpackage

[rtl/dnle_encoder.sv]
module dnle_encoder import dnle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] name_char_i,
  input  logic       name_end_i,
  output push_t      push_o
);

  logic [7:0] label_base_q, label_base_d;
  logic [5:0] label_count_q, label_count_d;
  logic [1:0] dot_run_q, dot_run_d;
  logic [7:0] strip_len_q, strip_len_d;
  logic       label_fault_q, label_fault_d;
  logic       len_fault_q, len_fault_d;

  always_comb begin
    logic       is_dot;
    logic       clean;
    logic [1:0] k;
    res_t       r;
    logic [7:0] term;

    push_o        = '0;
    k             = 2'd0;
    r             = '0;
    term          = '0;
    is_dot        = (name_char_i == SEPARATOR);
    clean         = !label_fault_q && !len_fault_q;
    label_base_d  = label_base_q;
    label_count_d = label_count_q;
    dot_run_d     = dot_run_q;
    label_fault_d = label_fault_q;
    len_fault_d   = len_fault_q;
    strip_len_d   = (strip_len_q < LEN_SATURATE) ? strip_len_q + 8'd1 : strip_len_q;

    if (is_dot) begin
      if (clean) begin
        if (label_count_q != '0) begin
          r = '{out_byte: {2'b00, label_count_q}, out_offset: label_base_q,
                store: 1'b1, done_res: 1'b0, status: ST_OK};
          push_o.ents[k] = r;
          k = k + 2'd1;
          label_base_d  = label_base_q + {2'b00, label_count_q} + 8'd1;
          label_count_d = '0;
          dot_run_d     = 2'd1;
        end else if (dot_run_q < 2'd2) begin
          dot_run_d = dot_run_q + 2'd1;
        end
      end
    end else begin
      if (strip_len_d > NAME_MAX_LEN) len_fault_d = 1'b1;
      if (!label_fault_q) begin
        // empty label: after a double dot or after leading dots
        if (label_count_q == '0 && dot_run_q != '0 &&
            (dot_run_q >= 2'd2 || label_base_q == '0))
          label_fault_d = 1'b1;
        if (label_count_q >= LABEL_MAX_LEN) label_fault_d = 1'b1;
      end
      if (!label_fault_d && !len_fault_d) begin
        r = '{out_byte: name_char_i,
              out_offset: label_base_q + 8'd1 + {2'b00, label_count_q},
              store: 1'b1, done_res: 1'b0, status: ST_OK};
        push_o.ents[k] = r;
        k = k + 2'd1;
        label_count_d = label_count_q + 6'd1;
        dot_run_d     = '0;
      end
    end

    if (name_end_i) begin
      if (len_fault_d) begin
        r = '{out_byte: '0, out_offset: '0, store: 1'b0, done_res: 1'b1,
              status: ST_TOO_LONG};
      end else if (label_fault_d) begin
        r = '{out_byte: '0, out_offset: '0, store: 1'b0, done_res: 1'b1,
              status: ST_BAD_LABEL};
      end else begin
        term = label_base_d;
        if (label_count_d != '0) begin
          push_o.ents[k] = '{out_byte: {2'b00, label_count_d}, out_offset: label_base_d,
                             store: 1'b1, done_res: 1'b0, status: ST_OK};
          k = k + 2'd1;
          term = label_base_d + 8'd1 + {2'b00, label_count_d};
        end
        r = '{out_byte: '0, out_offset: term, store: 1'b1, done_res: 1'b1,
              status: ST_OK};
      end
      push_o.ents[k] = r;
      k = k + 2'd1;
      label_base_d  = '0;
      label_count_d = '0;
      dot_run_d     = '0;
      strip_len_d   = '0;
      label_fault_d = 1'b0;
      len_fault_d   = 1'b0;
    end

    push_o.n = fire_i ? k : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_base_q  <= '0;
      label_count_q <= '0;
      dot_run_q     <= '0;
      strip_len_q   <= '0;
      label_fault_q <= 1'b0;
      len_fault_q   <= 1'b0;
    end else if (fire_i) begin
      label_base_q  <= label_base_d;
      label_count_q <= label_count_d;
      dot_run_q     <= dot_run_d;
      strip_len_q   <= strip_len_d;
      label_fault_q <= label_fault_d;
      len_fault_q   <= len_fault_d;
    end
  end

endmodule

[rtl/dnle_res_fifo.sv]
module dnle_res_fifo import dnle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  head_o
);

  res_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            pop;

  // room for a worst-case burst, ignoring a pop in the same cycle
  assign room_o  = (count_q <= (PtrW + 1)'(FifoDepth - MaxPush));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + (PtrW + 1)'(push_i.n) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxPush; i++) begin
      if (2'(i) < push_i.n) mem_q[PtrW'(wr_ptr_q + PtrW'(i))] <= push_i.ents[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/dns_name_label_encoder_unit.sv]
// Streaming encoder from a dotted domain name to DNS wire-form label bytes.
// Input channel: one name character per transfer (name_char_i, with
// name_end_i high on the last one). Output channel: one byte write per
// transfer (out_byte_o at out_offset_o when store_o is high); the last
// result of every name carries done_res_o and status_o (ok, too long,
// bad label). A character yields zero to three results.
// A character taken is held in the input register, is encoded from there
// into an 8-entry result queue once the queue has room, and its first
// result is then offered from the head of that queue.
// Throughput: one character per cycle while the queue holds five or fewer
// results; the queue drains one result per cycle while out_ready_i is high,
// so names whose steps produce several results are paced by the output side.
// Receiver stall: results wait in the queue and the input register keeps
// taking characters until the queue lacks space for a full three-result
// burst; then in_ready_o drops until results are drained.
// Reset: clears label state, fault flags, input register and queue; the
// block is ready for a new name at once.
module dns_name_label_encoder_unit import dnle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] name_char_i,
  input  logic       name_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [7:0] out_offset_o,
  output logic       store_o,
  output logic       done_res_o,
  output logic [1:0] status_o
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] char_q;
  logic       end_q;

  logic  room;
  logic  fire;
  push_t push;
  res_t  head;

  // the registered character is encoded once the queue can take its burst
  assign fire       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) in_vld_d = 1'b1;
    else if (fire)                in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= name_char_i;
      end_q  <= name_end_i;
    end
  end

  dnle_encoder u_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .name_char_i (char_q),
    .name_end_i  (end_q),
    .push_o      (push)
  );

  dnle_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign out_byte_o   = head.out_byte;
  assign out_offset_o = head.out_offset;
  assign store_o      = head.store;
  assign done_res_o   = head.done_res;
  assign status_o     = head.status;

endmodule

[rtl/dnle_checker.sv]
module dnle_checker import dnle_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] name_char_i,
  input logic       name_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [7:0] out_offset_o,
  input logic       store_o,
  input logic       done_res_o,
  input logic [1:0] status_o
);

  // a waiting character is held by the sender until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i &&
      $stable(name_char_i) && $stable(name_end_i))
    else $error("input character changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(out_byte_o) && $stable(out_offset_o) && $stable(store_o) &&
      $stable(done_res_o) && $stable(status_o))
    else $error("output result changed while stalled");

  // intermediate results are always writes with a clean status
  a_mid_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> store_o && status_o == ST_OK)
    else $error("non-final result is not a plain write");

  // a final write is the terminator of a clean name
  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && store_o |-> status_o == ST_OK && out_byte_o == '0)
    else $error("bad terminator result");

  // a faulted end stores nothing and reports a fault at offset zero
  a_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && !store_o |->
      (status_o == ST_TOO_LONG || status_o == ST_BAD_LABEL) &&
      out_byte_o == '0 && out_offset_o == '0)
    else $error("bad fault result");

endmodule

bind dns_name_label_encoder_unit dnle_checker u_dnle_checker (.*);

[dv/tb_dns_name_label_encoder_unit.sv]
module tb_dns_name_label_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dnle_pkg::*;

  // Receiver hold-off window, counted in cycles after reset, and the windows
  // in which neither side idles.
  localparam int HoldStart   = 150;
  localparam int HoldLen     = 60;
  localparam int RxQuietLo   = 220;
  localparam int RxQuietHi   = 420;
  localparam int TxQuietLo   = 100;
  localparam int TxQuietHi   = 300;
  localparam int RandItems   = 20;
  localparam int DrainCycles = 20;

  typedef logic [7:0] char_q_t[$];

  // One row of the directed table: a character, its end flag and, where the
  // wire bytes are obvious, the results typed in by hand.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       fixed;
    push_t      want;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] name_char_i = 8'h00;
  logic       name_end_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [7:0] out_offset_o;
  logic       store_o;
  logic       done_res_o;
  logic [1:0] status_o;

  // Byte writes still owed by the block, oldest first.
  res_t wire_q[$];
  int   n_err   = 0;
  int   n_items = 0;

  // Encoder state as the predictor sees it.
  logic [7:0] lab_base = 8'd0;
  logic [5:0] lab_cnt  = 6'd0;
  logic [1:0] dots     = 2'd0;
  logic [7:0] seen_len = 8'd0;
  logic       bad_lab  = 1'b0;
  logic       too_long = 1'b0;

  dns_name_label_encoder_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .name_char_i  (name_char_i),
    .name_end_i   (name_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .out_offset_o (out_offset_o),
    .store_o      (store_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic res_t mk_res(input logic [7:0] b, input logic [7:0] off,
                                  input logic st, input logic dn, input status_e s);
    res_t r;
    r.out_byte   = b;
    r.out_offset = off;
    r.store      = st;
    r.done_res   = dn;
    r.status     = s;
    return r;
  endfunction

  function automatic void add_res(inout push_t p, input res_t r);
    p.ents[p.n] = r;
    p.n++;
  endfunction

  // Wire-form writes caused by one character; advances the label state.
  function automatic push_t encode_char(input logic [7:0] c, input logic fin);
    push_t      p;
    logic [7:0] term;
    p = '0;
    if (seen_len < LEN_SATURATE) seen_len++;
    if (c == SEPARATOR) begin
      // a dot closes an open label; dots on an empty label only count up
      if (!bad_lab && !too_long) begin
        if (lab_cnt != 6'd0) begin
          add_res(p, mk_res(8'(lab_cnt), lab_base, 1'b1, 1'b0, ST_OK));
          lab_base = lab_base + 8'(lab_cnt) + 8'd1;
          lab_cnt  = 6'd0;
          dots     = 2'd1;
        end else if (dots < 2'd2) begin
          dots++;
        end
      end
    end else begin
      if (seen_len > NAME_MAX_LEN) too_long = 1'b1;
      if (!bad_lab) begin
        // empty label: leading dot(s), or two dots in a row
        if (lab_cnt == 6'd0 && dots != 2'd0 && (dots >= 2'd2 || lab_base == 8'd0))
          bad_lab = 1'b1;
        if (lab_cnt >= LABEL_MAX_LEN) bad_lab = 1'b1;
      end
      if (!bad_lab && !too_long) begin
        add_res(p, mk_res(c, lab_base + 8'd1 + 8'(lab_cnt), 1'b1, 1'b0, ST_OK));
        lab_cnt++;
        dots = 2'd0;
      end
    end
    if (fin) begin
      if (too_long) begin
        add_res(p, mk_res(8'd0, 8'd0, 1'b0, 1'b1, ST_TOO_LONG));
      end else if (bad_lab) begin
        add_res(p, mk_res(8'd0, 8'd0, 1'b0, 1'b1, ST_BAD_LABEL));
      end else begin
        term = lab_base;
        if (lab_cnt != 6'd0) begin
          add_res(p, mk_res(8'(lab_cnt), lab_base, 1'b1, 1'b0, ST_OK));
          term = lab_base + 8'd1 + 8'(lab_cnt);
        end
        add_res(p, mk_res(8'd0, term, 1'b1, 1'b1, ST_OK));
      end
      lab_base = 8'd0;
      lab_cnt  = 6'd0;
      dots     = 2'd0;
      seen_len = 8'd0;
      bad_lab  = 1'b0;
      too_long = 1'b0;
    end
    return p;
  endfunction

  function automatic row_t plain_row(input logic [7:0] c, input logic fin);
    row_t r;
    r     = '0;
    r.ch  = c;
    r.fin = fin;
    return r;
  endfunction

  function automatic row_t fixed_row(input logic [7:0] c, input logic fin, input logic [1:0] n,
                                     input res_t e0, input res_t e1, input res_t e2);
    row_t r;
    r              = plain_row(c, fin);
    r.fixed        = 1'b1;
    r.want.n       = n;
    r.want.ents[0] = e0;
    r.want.ents[1] = e1;
    r.want.ents[2] = e2;
    return r;
  endfunction

  // Label of random non-dot characters, full byte range otherwise.
  function automatic void add_label(ref char_q_t q, input int len);
    logic [7:0] c;
    repeat (len) begin
      do c = 8'($urandom_range(0, 255)); while (c == SEPARATOR);
      q = {q, c};
    end
  endfunction

  // Three 63-character labels, a last one of the given length and trail trailing dots.
  function automatic void long_name(ref char_q_t q, input int last, input int trail);
    q = {};
    for (int j = 0; j < 4; j++) begin
      if (j != 0) q = {q, SEPARATOR};
      add_label(q, (j < 3) ? 63 : last);
    end
    repeat (trail) q = {q, SEPARATOR};
  endfunction

  // Mostly well-formed names with random content, some with one defect,
  // and a share of plain noise.
  function automatic void rand_name(ref char_q_t q);
    int kind;
    int flaw;
    int nlab;
    int bad_at;
    int len;
    q    = {};
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      len = $urandom_range(1, 12);
      repeat (len)
        q = {q, (($urandom_range(0, 2) == 0) ? SEPARATOR : 8'($urandom_range(0, 255)))};
      return;
    end
    // flaw 1: leading dots, 2: empty label inside, 3: label over 63
    flaw   = (kind >= 65) ? $urandom_range(1, 3) : 0;
    nlab   = $urandom_range((flaw == 2) ? 2 : 1, 4);
    bad_at = $urandom_range((flaw == 2) ? 1 : 0, nlab - 1);
    if (flaw == 1) repeat ($urandom_range(1, 2)) q = {q, SEPARATOR};
    for (int j = 0; j < nlab; j++) begin
      if (j != 0) begin
        q = {q, SEPARATOR};
        if (flaw == 2 && j == bad_at) q = {q, SEPARATOR};
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
      if (flaw == 3 && j == bad_at) len = $urandom_range(64, 66);
      add_label(q, len);
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q = {q, SEPARATOR};
  endfunction

  // Offer one character from a falling edge and hold it until the transfer.
  // Returns at the falling edge after the transfer, valid still high, so a
  // following character goes out back to back.
  task automatic offer(input logic [7:0] c, input logic fin, input logic fixed,
                       input push_t want);
    push_t p;
    if (!(n_items >= TxQuietLo && n_items < TxQuietHi) && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    name_char_i <= c;
    name_end_i  <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    p = encode_char(c, fin);
    if (fixed) p = want;
    for (int k = 0; k < p.n; k++) wire_q = {wire_q, p.ents[k]};
    @(negedge clk_i);
  endtask

  task automatic send_name(input char_q_t q);
    foreach (q[i]) offer(q[i], i == q.size() - 1, 1'b0, '0);
  endtask

  // Receiver: random back-pressure, one long hold-off while the sender keeps
  // going (fills the result queue and stalls the input), and a quiet window.
  initial begin : rx_side
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen)
        out_ready_i <= 1'b0;
      else if (cyc >= RxQuietLo && cyc < RxQuietHi)
        out_ready_i <= 1'b1;
      else
        out_ready_i <= ($urandom_range(0, 99) >= 7);
    end
  end

  // Every result transfer is matched against the oldest owed write.
  // Fields are shown as byte/offset/store/done/status.
  always @(posedge clk_i) begin : wire_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (wire_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result: expected none, got %02h/%0d/%0b/%0b/%0d",
                 $time, out_byte_o, out_offset_o, store_o, done_res_o, status_o);
      end else begin
        want = wire_q.pop_front();
        if (out_byte_o !== want.out_byte || out_offset_o !== want.out_offset ||
            store_o !== want.store || done_res_o !== want.done_res ||
            status_o !== want.status) begin
          n_err++;
          $display("%0t: mismatch: expected %02h/%0d/%0b/%0b/%0d, got %02h/%0d/%0b/%0b/%0d",
                   $time, want.out_byte, want.out_offset, want.store, want.done_res,
                   want.status, out_byte_o, out_offset_o, store_o, done_res_o, status_o);
        end
      end
    end
  end

  initial begin : tx_side
    row_t    dir_rows[$];
    char_q_t nm;
    res_t    bad;
    int      rand_stop;

    bad = mk_res(8'd0, 8'd0, 1'b0, 1'b1, ST_BAD_LABEL);

    // all-dot name: a lone zero byte
    dir_rows = {dir_rows, fixed_row(SEPARATOR, 1'b1, 2'd1,
                                    mk_res(8'd0, 8'd0, 1'b1, 1'b1, ST_OK), '0, '0)};
    // one-character names at the byte extremes
    dir_rows = {dir_rows, fixed_row(8'hFF, 1'b1, 2'd3,
                                    mk_res(8'hFF, 8'd1, 1'b1, 1'b0, ST_OK),
                                    mk_res(8'd1, 8'd0, 1'b1, 1'b0, ST_OK),
                                    mk_res(8'd0, 8'd2, 1'b1, 1'b1, ST_OK))};
    dir_rows = {dir_rows, fixed_row(8'h00, 1'b1, 2'd3,
                                    mk_res(8'h00, 8'd1, 1'b1, 1'b0, ST_OK),
                                    mk_res(8'd1, 8'd0, 1'b1, 1'b0, ST_OK),
                                    mk_res(8'd0, 8'd2, 1'b1, 1'b1, ST_OK))};
    // "a.b.." : trailing dots dropped, end on a dot
    dir_rows = {dir_rows, plain_row("a", 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, plain_row("b", 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b1)};
    // ".x" : single leading dot
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, fixed_row("x", 1'b1, 2'd1, bad, '0, '0)};
    // "..xy." : after the fault nothing comes until the end
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, fixed_row("x", 1'b0, 2'd0, '0, '0, '0)};
    dir_rows = {dir_rows, fixed_row("y", 1'b0, 2'd0, '0, '0, '0)};
    dir_rows = {dir_rows, fixed_row(SEPARATOR, 1'b1, 2'd1, bad, '0, '0)};
    // "a..b" : empty label in the middle
    dir_rows = {dir_rows, plain_row("a", 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, fixed_row("b", 1'b1, 2'd1, bad, '0, '0)};
    // "cd.e" : open label closed by the end flag
    dir_rows = {dir_rows, plain_row("c", 1'b0)};
    dir_rows = {dir_rows, plain_row("d", 1'b0)};
    dir_rows = {dir_rows, plain_row(SEPARATOR, 1'b0)};
    dir_rows = {dir_rows, plain_row("e", 1'b1)};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      offer(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].fixed, dir_rows[i].want);

    // Long names: 254 stripped characters (the 253rd is still written, the
    // 254th runs too long), and a single 64-character label.
    long_name(nm, 62, 0);
    send_name(nm);
    nm = {};
    add_label(nm, 64);
    send_name(nm);

    rand_stop = n_items + RandItems;
    while (n_items < rand_stop) begin
      rand_name(nm);
      send_name(nm);
    end
    in_valid_i <= 1'b0;

    while (wire_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dnle_pkg.sv
rtl/dnle_encoder.sv
rtl/dnle_res_fifo.sv
rtl/dns_name_label_encoder_unit.sv
rtl/dnle_checker.sv
dv/tb_dns_name_label_encoder_unit.sv
